@@ src/assert_macros.svh @@
// Assertion macros used by the checker module of the deque.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/deq_pkg.sv @@
// Shared types and constants of the double-ended ring queue.
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   typedef enum logic [1:0] {
      CMD_PUSH_HEAD = 2'd0,
      CMD_PUSH_TAIL = 2'd1,
      CMD_POP_HEAD  = 2'd2,
      CMD_POP_TAIL  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic        wr_en;
      logic [31:0] wr_data;
   } cell_ctl_type;

endpackage

@@ src/deq_cell.sv @@
// One storage cell of the ring; passes the selected word down the read chain.
module deq_cell
   import deq_pkg::*;
#(
   parameter int IW  = 4,
   parameter int IDX = 0
) (
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  logic [IW-1:0] wr_idx,
   input  logic [IW-1:0] rd_idx,
   input  logic [31:0]   chain_in,
   output logic [31:0]   chain_out
);

   logic [31:0] word_ff;
   logic [31:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.wr_en && (wr_idx == IW'(IDX))) begin
         word_in = ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // A cell that is not addressed forwards the word arriving on its chain input from upstream.
   assign chain_out = (rd_idx == IW'(IDX)) ? word_ff : chain_in;

endmodule

@@ src/deq_ctrl.sv @@
// Pointer, count and capacity control of the deque, with the result register.
module deq_ctrl
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int IW    = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          req_command,
   input  logic signed [31:0]  req_push_value,
   input  logic                csr_write,
   input  logic [4:0]          csr_data,
   input  logic [31:0]         rd_word,
   output cell_ctl_type        cell_ctl,
   output logic [IW-1:0]       wr_idx,
   output logic [IW-1:0]       rd_idx,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_popped_value,
   output logic [4:0]          rsp_occupancy,
   output logic                rsp_is_empty,
   output logic                rsp_is_full
);

   localparam int PW = ((IW > 5) ? IW : 5) + 1;

   logic [4:0]    cap_ff, cap_in;
   logic [4:0]    count_ff, count_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic          strobe_ff, strobe_in;
   status_type    status_ff, status_in;
   logic [31:0]   popped_ff, popped_in;
   logic [4:0]    occ_ff;
   logic          empty_ff, full_ff;
   cmd_type       cmd;

   function automatic logic [4:0] eff_cap(input logic [4:0] v);
      if (v == 5'd0) begin
         return 5'd1;
      end
      if (32'(v) > 32'(DEPTH)) begin
         return 5'(DEPTH);
      end
      return v;
   endfunction

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx,
                                               input logic [4:0] cap);
      logic [PW-1:0] s;
      s = PW'(idx) + PW'(1);
      if (s >= PW'(cap)) begin
         return '0;
      end
      return IW'(s);
   endfunction

   function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx,
                                               input logic [4:0] cap);
      if ((idx == '0) || (PW'(idx) > PW'(cap))) begin
         return IW'(PW'(cap) - PW'(1));
      end
      return idx - IW'(1);
   endfunction

   assign cmd = cmd_type'(req_command);

   always_comb begin
      cap_in           = cap_ff;
      count_in         = count_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      strobe_in        = accept;
      status_in        = STAT_DONE;
      popped_in        = '0;
      cell_ctl.wr_en   = 1'b0;
      cell_ctl.wr_data = req_push_value;
      wr_idx           = '0;
      rd_idx           = (cmd == CMD_POP_TAIL) ? tail_ff : head_ff;

      if (csr_write) begin
         cap_in   = eff_cap(csr_data);
         count_in = '0;
         head_in  = '0;
         tail_in  = '0;
      end else if (accept) begin
         if ((cmd == CMD_PUSH_HEAD) || (cmd == CMD_PUSH_TAIL)) begin
            if (count_ff >= cap_ff) begin
               status_in = STAT_OVERFLOW;
            end else begin
               cell_ctl.wr_en = 1'b1;
               if (count_ff == 5'd0) begin
                  // The first word always lands in entry zero.
                  head_in = '0;
                  tail_in = '0;
                  wr_idx  = '0;
               end else if (cmd == CMD_PUSH_HEAD) begin
                  head_in = ring_prev(head_ff, cap_ff);
                  wr_idx  = head_in;
               end else begin
                  tail_in = ring_next(tail_ff, cap_ff);
                  wr_idx  = tail_in;
               end
               count_in = count_ff + 5'd1;
            end
         end else begin
            if (count_ff == 5'd0) begin
               status_in = STAT_UNDERFLOW;
            end else begin
               popped_in = rd_word;
               if (cmd == CMD_POP_HEAD) begin
                  head_in = ring_next(head_ff, cap_ff);
               end else begin
                  tail_in = ring_prev(tail_ff, cap_ff);
               end
               count_in = count_ff - 5'd1;
               if (count_in == 5'd0) begin
                  head_in = '0;
                  tail_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= eff_cap(CAPACITY_RESET);
         count_ff  <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         cap_ff    <= cap_in;
         count_ff  <= count_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
      occ_ff    <= count_in;
      empty_ff  <= (count_in == 5'd0);
      full_ff   <= (count_in >= cap_in);
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_occupancy    = occ_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_is_full      = full_ff;

endmodule

@@ src/double_ended_ring_queue_core.sv @@
// Top level of the double-ended ring queue: control plus a row of storage cells.
// The result of a request shows on rsp_strobe in the cycle after acceptance.
// Throughput: one request per cycle; a pop reads its word through the cell chain.
// busy stays low, so start is taken every cycle; results cannot be stalled.
// Reset empties the queue and sets the capacity to 16, or DEPTH if smaller; cell contents are kept.
module double_ended_ring_queue_core
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_popped_value,
   output logic [4:0]         rsp_occupancy,
   output logic               rsp_is_empty,
   output logic               rsp_is_full,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_data
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cell_ctl_type  cell_ctl;
   logic [IW-1:0] wr_idx;
   logic [IW-1:0] rd_idx;
   logic [31:0]   chain [DEPTH+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign chain[0]  = '0;

   deq_ctrl #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (start && !busy),
      .req_command      (req_command),
      .req_push_value   (req_push_value),
      .csr_write        (csr_valid && csr_ready),
      .csr_data         (csr_data),
      .rd_word          (chain[DEPTH]),
      .cell_ctl         (cell_ctl),
      .wr_idx           (wr_idx),
      .rd_idx           (rd_idx),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      deq_cell #(
         .IW  (IW),
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .wr_idx    (wr_idx),
         .rd_idx    (rd_idx),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

endmodule

@@ src/deq_checker.sv @@
// Port-level checker of the double-ended ring queue and its bind statement.
`include "assert_macros.svh"

module deq_checker
   import deq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_popped_value,
   input logic [4:0]         rsp_occupancy,
   input logic               rsp_is_empty,
   input logic               rsp_is_full
);

   // Every accepted request gets its result in the next cycle, and nothing else does.
   `ASSERT_RST(a_one_result, clock, reset, (start && !busy) |=> rsp_strobe, "request without result")
   `ASSERT_RST(a_no_extra, clock, reset, !(start && !busy) |=> !rsp_strobe, "result without request")
   `ASSERT_ALWAYS(a_empty_flag, clock, rsp_strobe |-> (rsp_is_empty == (rsp_occupancy == 5'd0)), "empty flag disagrees with occupancy")
   `ASSERT_ALWAYS(a_pop_zero, clock, (rsp_strobe && (rsp_status != STAT_DONE)) |-> (rsp_popped_value == 32'sd0), "failed request returned a word")
   `ASSERT_ALWAYS(a_under_empty, clock, (rsp_strobe && (rsp_status == STAT_UNDERFLOW)) |-> (rsp_is_empty && !rsp_is_full), "underflow on a non-empty queue")

endmodule

bind double_ended_ring_queue_core deq_checker u_deq_checker (.*);

@@ tb/sv/double_ended_ring_queue_core_tb.sv @@
// Self-checking testbench for the double-ended ring queue core.
`timescale 1ns / 1ps

import deq_pkg::*;

typedef struct {
   status_type  status;
   logic [31:0] popped;
   logic [4:0]  occupancy;
   logic        is_empty;
   logic        is_full;
} deque_result_type;

class deque_scoreboard_type;
   int unsigned      errors;
   logic [4:0]       capacity_reg;
   logic [31:0]      ring[DEPTH_DEFAULT];
   int unsigned      head;
   int unsigned      tail;
   int unsigned      count;
   deque_result_type pending_results[$];

   function new();
      errors = 0;
      capacity_reg = CAPACITY_RESET;
      head = 0;
      tail = 0;
      count = 0;
      foreach (ring[i]) ring[i] = '0;
   endfunction

   // A capacity write also empties the queue.
   function void write_capacity(logic [4:0] cap_value);
      capacity_reg = cap_value;
      head = 0;
      tail = 0;
      count = 0;
   endfunction

   function int unsigned usable_entries();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > DEPTH_DEFAULT) return DEPTH_DEFAULT;
      return capacity_reg;
   endfunction

   function int unsigned wrap_up(int unsigned idx, int unsigned cap);
      return (idx + 1 >= cap) ? 0 : idx + 1;
   endfunction

   function int unsigned wrap_down(int unsigned idx, int unsigned cap);
      if (idx == 0 || idx > cap) return cap - 1;
      return idx - 1;
   endfunction

   function int unsigned outstanding();
      return pending_results.size();
   endfunction

   // Updates the queue image for one accepted request and records its result.
   function void note_request(cmd_type cmd, logic [31:0] word);
      int unsigned      cap;
      deque_result_type res;
      cap = usable_entries();
      res.status = STAT_DONE;
      res.popped = '0;
      if (cmd == CMD_PUSH_HEAD || cmd == CMD_PUSH_TAIL) begin
         if (count >= cap) begin
            res.status = STAT_OVERFLOW;
         end else begin
            if (count == 0) begin
               head = 0;
               tail = 0;
               ring[0] = word;
            end else if (cmd == CMD_PUSH_HEAD) begin
               head = wrap_down(head, cap);
               ring[head % DEPTH_DEFAULT] = word;
            end else begin
               tail = wrap_up(tail, cap);
               ring[tail % DEPTH_DEFAULT] = word;
            end
            count++;
         end
      end else begin
         if (count == 0) begin
            res.status = STAT_UNDERFLOW;
         end else begin
            if (cmd == CMD_POP_HEAD) begin
               res.popped = ring[head % DEPTH_DEFAULT];
               head = wrap_up(head, cap);
            end else begin
               res.popped = ring[tail % DEPTH_DEFAULT];
               tail = wrap_down(tail, cap);
            end
            count--;
            if (count == 0) begin
               head = 0;
               tail = 0;
            end
         end
      end
      res.occupancy = count[4:0];
      res.is_empty = (count == 0);
      res.is_full = (count >= cap);
      pending_results.push_back(res);
   endfunction

   function void check_result(logic [1:0] st, logic [31:0] pv, logic [4:0] occ,
                              logic em, logic fu);
      deque_result_type res;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result status=%0d popped=%h occupancy=%0d",
                  $time, st, pv, occ);
         errors++;
         return;
      end
      res = pending_results.pop_front();
      if (st !== res.status) begin
         $display("%0t: status expected %0d actual %0d", $time, res.status, st);
         errors++;
      end
      if (pv !== res.popped) begin
         $display("%0t: popped_value expected %h actual %h", $time, res.popped, pv);
         errors++;
      end
      if (occ !== res.occupancy) begin
         $display("%0t: occupancy expected %0d actual %0d", $time, res.occupancy, occ);
         errors++;
      end
      if (em !== res.is_empty) begin
         $display("%0t: is_empty expected %b actual %b", $time, res.is_empty, em);
         errors++;
      end
      if (fu !== res.is_full) begin
         $display("%0t: is_full expected %b actual %b", $time, res.is_full, fu);
         errors++;
      end
   endfunction
endclass

module double_ended_ring_queue_core_tb;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PHASE = 170;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_command = CMD_PUSH_HEAD;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_popped_value;
   logic [4:0]         rsp_occupancy;
   logic               rsp_is_empty;
   logic               rsp_is_full;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [4:0]         csr_data = '0;

   int unsigned          cycle_count = 0;
   int unsigned          idle_pct = 0;
   deque_scoreboard_type sb = new();

   double_ended_ring_queue_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_push_value   (req_push_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Requests are noted before results are checked; a result shows in the cycle after its
   // request, so the two never refer to the same request at one edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_capacity(csr_data);
         if (start && !busy) sb.note_request(cmd_type'(req_command), req_push_value);
         if (rsp_strobe) begin
            sb.check_result(rsp_status, rsp_popped_value, rsp_occupancy,
                            rsp_is_empty, rsp_is_full);
         end
      end
   end

   task automatic send_request(cmd_type cmd, logic [31:0] word);
      logic stalled;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_push_value <= word;
      do begin
         @(negedge clock);
         stalled = busy;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_capacity(logic [4:0] cap_value);
      logic accepted;
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= cap_value;
      do begin
         @(negedge clock);
         accepted = csr_ready;
         @(posedge clock);
      end while (!accepted);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Alternates push-heavy and pop-heavy runs so the queue keeps hitting both
   // full and empty, with overflow and underflow along the way.
   task automatic random_phase(logic [4:0] cap_value, int unsigned pct);
      int unsigned run_left;
      int unsigned push_pct;
      int unsigned span;
      cmd_type     cmd;
      set_capacity(cap_value);
      idle_pct = pct;
      span = (cap_value == 0) ? 1 : ((cap_value > 16) ? 16 : cap_value);
      run_left = 0;
      push_pct = 80;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(3 * span + 2, 1);
            push_pct = (push_pct > 50) ? 20 : 80;
            if ($urandom_range(9) == 0) push_pct = 50;
         end
         run_left--;
         if ($urandom_range(99) < push_pct)
            cmd = $urandom_range(1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD;
         else
            cmd = $urandom_range(1) ? CMD_POP_TAIL : CMD_POP_HEAD;
         send_request(cmd, random_word());
      end
      idle_pct = 0;
   endtask

   initial begin
      logic [4:0]  phase_caps[10];
      int unsigned phase_idle[3];
      phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd17, 5'd7, 5'd2, 5'd12, 5'd5};
      phase_idle = '{0, 84, 16};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Underflow at both ends, extreme words, pops back down to empty.
      send_request(CMD_POP_HEAD, 32'h1234_5678);
      send_request(CMD_POP_TAIL, 32'h0);
      send_request(CMD_PUSH_HEAD, 32'h8000_0000);
      send_request(CMD_PUSH_TAIL, 32'h7fff_ffff);
      send_request(CMD_PUSH_HEAD, 32'hffff_ffff);
      send_request(CMD_PUSH_TAIL, 32'h0000_0000);
      send_request(CMD_POP_HEAD, 32'h0);
      send_request(CMD_POP_TAIL, 32'h0);
      send_request(CMD_POP_TAIL, 32'h0);
      send_request(CMD_POP_HEAD, 32'h0);
      send_request(CMD_POP_TAIL, 32'h0);

      // A capacity of zero behaves as a single entry.
      set_capacity(5'd0);
      send_request(CMD_PUSH_TAIL, 32'h5a5a_a5a5);
      send_request(CMD_PUSH_HEAD, 32'ha5a5_5a5a);
      send_request(CMD_POP_TAIL, 32'h0);
      send_request(CMD_POP_HEAD, 32'h0);

      // Head pointer wraps below entry zero in a two-entry ring.
      set_capacity(5'd2);
      send_request(CMD_PUSH_HEAD, 32'h0000_0001);
      send_request(CMD_PUSH_HEAD, 32'hfffe_0002);
      send_request(CMD_PUSH_TAIL, 32'h0000_0003);
      send_request(CMD_POP_TAIL, 32'h0);
      send_request(CMD_POP_TAIL, 32'h0);

      for (int p = 0; p < 10; p++) random_phase(phase_caps[p], phase_idle[p % 3]);

      drain_results();
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
